[design/lpc_pkg.sv]
// ----------------------------------------------------------------------------
// lpc_pkg: line position centroid shared definitions
// Field widths, register indexes, reset values and beat structs.
// ----------------------------------------------------------------------------
package lpc_pkg;

    localparam int SMP_W     = 12;
    localparam int MAX_LANES = 8;
    localparam int IDX_W     = 3;
    localparam int CNT_W     = 4;
    localparam int WSMP_W    = 15;
    localparam int SUM_W     = 15;
    localparam int USUM_W    = 17;
    localparam int SPC_W     = 12;
    localparam int WPROD_W   = USUM_W + SPC_W;
    localparam int QUO_W     = 15;
    localparam int POS_W     = 15;
    localparam int OFF_W     = 14;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    localparam logic [SMP_W-1:0] THRESHOLD_RST = 12'd4094;
    localparam logic [CNT_W-1:0] COUNT_RST     = 4'd8;
    localparam logic [SPC_W-1:0] SPACING_RST   = 12'd1000;
    localparam logic [CNT_W-1:0] COUNT_MIN     = 4'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_COUNT     = 2'd1,
        CFG_SPACING   = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [SMP_W-1:0] sample_0;
        logic [SMP_W-1:0] sample_1;
        logic [SMP_W-1:0] sample_2;
        logic [SMP_W-1:0] sample_3;
        logic [SMP_W-1:0] sample_4;
        logic [SMP_W-1:0] sample_5;
        logic [SMP_W-1:0] sample_6;
        logic [SMP_W-1:0] sample_7;
    } t_frame;

    typedef struct packed {
        logic signed [POS_W-1:0] line_position;
        logic                    line_found;
    } t_result;

    typedef struct packed {
        logic [WPROD_W-1:0] wsum;
        logic [SUM_W-1:0]   sum;
        logic               found;
    } t_merge_beat;

    typedef struct packed {
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] wlo;
        logic [SUM_W-1:0] dvs;
        logic [QUO_W-1:0] quo;
        logic             found;
    } t_div_beat;

endpackage

[design/lpc_lane.sv]
// ----------------------------------------------------------------------------
// lpc_lane: one sensor lane
// Thresholds and masks one sample and forms its index-weighted value.
// ----------------------------------------------------------------------------
module lpc_lane (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [lpc_pkg::SMP_W-1:0]   i_sample,
    input  logic [lpc_pkg::SMP_W-1:0]   i_threshold,
    input  logic [lpc_pkg::CNT_W-1:0]   i_count,
    input  logic [lpc_pkg::IDX_W-1:0]   i_lane_idx,
    output logic [lpc_pkg::SMP_W-1:0]   o_kept,
    output logic [lpc_pkg::WSMP_W-1:0]  o_weighted
);
    import lpc_pkg::*;

    logic [SMP_W-1:0]  n_kept;
    logic [WSMP_W-1:0] n_weighted;
    logic [SMP_W-1:0]  r_kept;
    logic [WSMP_W-1:0] r_weighted;

    always_comb begin
        if (i_sample >= i_threshold && CNT_W'(i_lane_idx) < i_count) begin
            n_kept = i_sample;
        end else begin
            n_kept = '0;
        end
        n_weighted = WSMP_W'(n_kept) * WSMP_W'(i_lane_idx);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kept     <= n_kept;
            r_weighted <= n_weighted;
        end
    end

    assign o_kept     = r_kept;
    assign o_weighted = r_weighted;

endmodule

[design/lpc_merge.sv]
// ----------------------------------------------------------------------------
// lpc_merge: lane merge
// Adds the lane results, then scales the weighted sum by the spacing.
// ----------------------------------------------------------------------------
module lpc_merge (
    input  logic                        i_clk,
    input  logic                        i_en_sum,
    input  logic                        i_en_mul,
    input  logic [lpc_pkg::SMP_W-1:0]   i_kept     [lpc_pkg::MAX_LANES],
    input  logic [lpc_pkg::WSMP_W-1:0]  i_weighted [lpc_pkg::MAX_LANES],
    input  logic [lpc_pkg::SPC_W-1:0]   i_spacing,
    output lpc_pkg::t_merge_beat        o_beat
);
    import lpc_pkg::*;

    logic [SUM_W-1:0]  n_sum;
    logic [USUM_W-1:0] n_usum;
    logic [SUM_W-1:0]  r_sum;
    logic [USUM_W-1:0] r_usum;
    t_merge_beat       n_beat;
    t_merge_beat       r_beat;

    always_comb begin
        n_sum  = '0;
        n_usum = '0;
        for (int k = 0; k < MAX_LANES; k++) begin
            n_sum  = n_sum + SUM_W'(i_kept[k]);
            n_usum = n_usum + USUM_W'(i_weighted[k]);
        end
    end

    always_comb begin
        n_beat.wsum  = WPROD_W'(r_usum) * WPROD_W'(i_spacing);
        n_beat.sum   = r_sum;
        n_beat.found = (r_sum != '0);
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_sum  <= n_sum;
            r_usum <= n_usum;
        end
        if (i_en_mul) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

[design/lpc_div_stage.sv]
// ----------------------------------------------------------------------------
// lpc_div_stage: one restoring divider step
// Shifts in one dividend bit and produces one quotient bit.
// ----------------------------------------------------------------------------
module lpc_div_stage (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  lpc_pkg::t_div_beat   i_beat,
    output lpc_pkg::t_div_beat   o_beat
);
    import lpc_pkg::*;

    logic [QUO_W:0] n_trial;
    logic           n_take;
    t_div_beat      n_beat;
    t_div_beat      r_beat;

    always_comb begin
        n_trial      = {i_beat.rem, i_beat.wlo[QUO_W-1]};
        n_take       = (n_trial >= {1'b0, i_beat.dvs});
        n_beat       = i_beat;
        n_beat.rem   = n_take ? QUO_W'(n_trial - {1'b0, i_beat.dvs}) : n_trial[QUO_W-1:0];
        n_beat.wlo   = {i_beat.wlo[QUO_W-2:0], 1'b0};
        n_beat.quo   = {i_beat.quo[QUO_W-2:0], n_take};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

[design/line_position_centroid_unit.sv]
// ----------------------------------------------------------------------------
// line_position_centroid_unit: line sensor position centroid
// Thresholds up to eight samples, forms the weighted average lane position
// and centers it on the middle of the array.
// ----------------------------------------------------------------------------
//  channel   signals                          dir  beat
//  frame     i_valid o_ready i_data           in   eight 12-bit samples
//  result    o_valid i_ready o_result         out  position and found flag
//  config    i_cfg_we i_cfg_idx i_cfg_data    in   one register write
//
//  One beat per cycle while i_ready holds; stages are lane, sum, multiply,
//  15 divider steps and output, the divider giving one quotient bit per step.
//  Reset clears the stage valid bits and loads register defaults.
//  A stall holds full stages only; empty stages keep filling upstream.
// ----------------------------------------------------------------------------
module line_position_centroid_unit #(
    parameter int LANES = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  lpc_pkg::t_frame                 i_data,
    output logic                            o_valid,
    input  logic                            i_ready,
    output lpc_pkg::t_result                o_result,
    input  logic                            i_cfg_we,
    input  logic [lpc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [lpc_pkg::CFG_DAT_W-1:0]   i_cfg_data
);
    import lpc_pkg::*;

    localparam int NSTG = 3 + QUO_W + 1;
    localparam logic [CNT_W-1:0] LANES_CNT = CNT_W'(LANES);

    logic [SMP_W-1:0]  r_threshold;
    logic [CNT_W-1:0]  r_count;
    logic [SPC_W-1:0]  r_spacing;

    logic [NSTG-1:0]   r_vld;
    logic [NSTG:0]     w_rdy;

    logic [CNT_W-1:0]  w_count;
    logic [IDX_W-1:0]  w_cnt_m1;
    logic [POS_W-1:0]  w_offprod;
    logic [OFF_W-1:0]  w_offset;

    logic [SMP_W-1:0]  w_smp      [MAX_LANES];
    logic [SMP_W-1:0]  w_kept     [MAX_LANES];
    logic [WSMP_W-1:0] w_weighted [MAX_LANES];

    t_merge_beat       w_merge;
    t_div_beat         w_div [QUO_W+1];

    logic [POS_W-1:0]  n_pos;
    t_result           n_result;
    t_result           r_result;

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_count     <= COUNT_RST;
            r_spacing   <= SPACING_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_THRESHOLD: r_threshold <= i_cfg_data[SMP_W-1:0];
                CFG_COUNT:     r_count     <= i_cfg_data[CNT_W-1:0];
                CFG_SPACING:   r_spacing   <= i_cfg_data[SPC_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        if (r_count < COUNT_MIN) begin
            w_count = COUNT_MIN;
        end else if (r_count > LANES_CNT) begin
            w_count = LANES_CNT;
        end else begin
            w_count = r_count;
        end
        w_cnt_m1  = IDX_W'(w_count - 1'b1);
        w_offprod = POS_W'(w_cnt_m1) * POS_W'(r_spacing);
        w_offset  = w_offprod[POS_W-1:1];
    end

    // stage handshake: a stage loads when empty or when its successor moves
    assign w_rdy[NSTG] = i_ready;
    for (genvar k = 0; k < NSTG; k++) begin : g_rdy
        assign w_rdy[k] = !r_vld[k] || w_rdy[k+1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NSTG-1];

    // lanes
    assign w_smp[0] = i_data.sample_0;
    assign w_smp[1] = i_data.sample_1;
    assign w_smp[2] = i_data.sample_2;
    assign w_smp[3] = i_data.sample_3;
    assign w_smp[4] = i_data.sample_4;
    assign w_smp[5] = i_data.sample_5;
    assign w_smp[6] = i_data.sample_6;
    assign w_smp[7] = i_data.sample_7;

    for (genvar g = 0; g < MAX_LANES; g++) begin : g_lane
        if (g < LANES) begin : g_on
            lpc_lane u_lane (
                .i_clk       (i_clk),
                .i_en        (w_rdy[0]),
                .i_sample    (w_smp[g]),
                .i_threshold (r_threshold),
                .i_count     (w_count),
                .i_lane_idx  (IDX_W'(g)),
                .o_kept      (w_kept[g]),
                .o_weighted  (w_weighted[g])
            );
        end else begin : g_off
            assign w_kept[g]     = '0;
            assign w_weighted[g] = '0;
        end
    end

    lpc_merge u_merge (
        .i_clk      (i_clk),
        .i_en_sum   (w_rdy[1]),
        .i_en_mul   (w_rdy[2]),
        .i_kept     (w_kept),
        .i_weighted (w_weighted),
        .i_spacing  (r_spacing),
        .o_beat     (w_merge)
    );

    // divider: quotient is below 2^15, so the top bits start as remainder
    always_comb begin
        w_div[0].rem   = QUO_W'(w_merge.wsum[WPROD_W-1:QUO_W]);
        w_div[0].wlo   = w_merge.wsum[QUO_W-1:0];
        w_div[0].dvs   = w_merge.sum;
        w_div[0].quo   = '0;
        w_div[0].found = w_merge.found;
    end

    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        lpc_div_stage u_div (
            .i_clk  (i_clk),
            .i_en   (w_rdy[3+j]),
            .i_beat (w_div[j]),
            .o_beat (w_div[j+1])
        );
    end

    // output
    always_comb begin
        n_pos = w_div[QUO_W].quo - POS_W'(w_offset);
        n_result.line_found = w_div[QUO_W].found;
        if (w_div[QUO_W].found) begin
            n_result.line_position = signed'(n_pos);
        end else begin
            n_result.line_position = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[NSTG-1]) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

`ifndef SYNTH
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !i_ready |-> !o_ready)
        else $error("input accepted while every stage is full and stalled");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[NSTG-2] && w_div[QUO_W].found |-> w_div[QUO_W].rem < w_div[QUO_W].dvs)
        else $error("divider remainder not below divisor");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_result.line_found |-> o_result.line_position == '0)
        else $error("nonzero position without a line");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.line_position >= -15'sd14332)
        else $error("position below the lowest centered value");
`endif

endmodule
